@@ rtl/ftoa_pkg.sv @@
// ----------------------------------------------------------------------------
// ftoa_pkg
// Shared types and constants for the float to decimal text formatter.
// ----------------------------------------------------------------------------
package ftoa_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Exponent field at or above this value: NaN, infinity or |x| >= 2^31
  localparam logic [7:0] EXP_ERR    = 8'd158;
  // Exponent at which the binary point sits just right of the significand
  localparam logic [7:0] EXP_UNIT   = 8'd150;

  // x / 10 == (x * RECIP10) >> RECIP_SH for every 32-bit x
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SH  = 35;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FSHIFT,
    ST_IMUL,
    ST_IDIV,
    ST_FRMUL,
    ST_FRDIV,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC,
    ST_ERR
  } ftoa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic fmul;
    logic fshift;
    logic imul;
    logic idiv;
    logic frmul;
    logic frdiv;
    logic emit_sign;
    logic emit_int;
    logic emit_point;
    logic emit_frac;
    logic emit_err;
    logic last;
  } ftoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    logic neg;
    logic d_zero;
    logic q_zero;
    logic f_last;
    logic int_one;
    logic frac_one;
    logic out_free;
  } ftoa_stat_t;

  // Powers of ten for the fraction scale
  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/float_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// float_to_decimal_ascii
// Formats one IEEE-754 single-precision value as decimal ASCII text.
// ----------------------------------------------------------------------------
// Input (in_valid / in_stall / value_bits): one 32-bit float pattern per item.
// Result (out_valid / out_stall / char_code / last / status): one character
//   per item, most significant first, last set on the final one. NaN,
//   infinity and |x| >= 2^31 give one item with char_code 0, last 1, status 1.
// Config (cfg_valid / cfg_ready / frac_digits): digits after the point; write
//   it only while the block is idle.
// Flow: a value gives 1..10 integer digits and 0..9 fraction digits. Once the
//   first character is valid the rest follow one per cycle, unless the
//   output stalls. The shared 32x32 multiplier does each divide-by-ten as a
//   multiply state followed by a divide state. in_stall is high from
//   acceptance until the last character is loaded, so a new value is not
//   accepted before the previous one has loaded its last character.
// Reset: clears the sequencer and output valid; frac_digits returns to 4.
// Stall: a stalled result holds in the output register and emission pauses.
// ----------------------------------------------------------------------------
module float_to_decimal_ascii #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  frac_digits,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value_bits,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_code,
  output logic        last,
  output logic        status
);

  ftoa_pkg::ftoa_cmd_t  cmd;
  ftoa_pkg::ftoa_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  ftoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftoa_dp #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .frac_digits (frac_digits),
    .value_bits  (value_bits),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .char_code   (char_code),
    .last        (last),
    .status      (status),
    .cmd         (cmd),
    .stat        (stat)
  );

  // a value in work blocks the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accept");

  // error result is a single terminal item with no character
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (last && (char_code == ftoa_pkg::CHAR_NONE)))
    else $error("malformed error item");

  // ok characters are digits, point or minus
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |->
      ((char_code >= ftoa_pkg::CHAR_ZERO && char_code <= 8'h39) ||
       char_code == ftoa_pkg::CHAR_POINT || char_code == ftoa_pkg::CHAR_MINUS))
    else $error("bad character code");

  // emission only while a value is in work
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_int || cmd.emit_frac) |-> in_stall)
    else $error("emission outside a value");

endmodule

@@ rtl/ftoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftoa_ctrl
// Sequencer: decode, fraction scaling, digit extraction, character emission.
// ----------------------------------------------------------------------------
module ftoa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ftoa_pkg::ftoa_stat_t stat,
  output ftoa_pkg::ftoa_cmd_t  cmd
);

  ftoa_pkg::ftoa_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ftoa_pkg::ST_IDLE);
    unique case (state)
      ftoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ftoa_pkg::ST_FMUL;
        end
      end
      ftoa_pkg::ST_FMUL: begin
        if (stat.err) begin
          state_next = ftoa_pkg::ST_ERR;
        end else begin
          cmd.fmul   = 1'b1;
          state_next = ftoa_pkg::ST_FSHIFT;
        end
      end
      ftoa_pkg::ST_FSHIFT: begin
        cmd.fshift = 1'b1;
        state_next = ftoa_pkg::ST_IMUL;
      end
      ftoa_pkg::ST_IMUL: begin
        cmd.imul   = 1'b1;
        state_next = ftoa_pkg::ST_IDIV;
      end
      ftoa_pkg::ST_IDIV: begin
        cmd.idiv = 1'b1;
        if (!stat.q_zero) begin
          state_next = ftoa_pkg::ST_IMUL;
        end else if (!stat.d_zero) begin
          state_next = ftoa_pkg::ST_FRMUL;
        end else if (stat.neg) begin
          state_next = ftoa_pkg::ST_SIGN;
        end else begin
          state_next = ftoa_pkg::ST_INT;
        end
      end
      ftoa_pkg::ST_FRMUL: begin
        cmd.frmul  = 1'b1;
        state_next = ftoa_pkg::ST_FRDIV;
      end
      ftoa_pkg::ST_FRDIV: begin
        cmd.frdiv = 1'b1;
        if (!stat.f_last) begin
          state_next = ftoa_pkg::ST_FRMUL;
        end else if (stat.neg) begin
          state_next = ftoa_pkg::ST_SIGN;
        end else begin
          state_next = ftoa_pkg::ST_INT;
        end
      end
      ftoa_pkg::ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ftoa_pkg::ST_INT;
        end
      end
      ftoa_pkg::ST_INT: begin
        if (stat.out_free) begin
          cmd.emit_int = 1'b1;
          cmd.last     = stat.d_zero && stat.int_one;
          if (stat.int_one) begin
            state_next = stat.d_zero ? ftoa_pkg::ST_IDLE : ftoa_pkg::ST_POINT;
          end
        end
      end
      ftoa_pkg::ST_POINT: begin
        if (stat.out_free) begin
          cmd.emit_point = 1'b1;
          state_next     = ftoa_pkg::ST_FRAC;
        end
      end
      ftoa_pkg::ST_FRAC: begin
        if (stat.out_free) begin
          cmd.emit_frac = 1'b1;
          cmd.last      = stat.frac_one;
          if (stat.frac_one) begin
            state_next = ftoa_pkg::ST_IDLE;
          end
        end
      end
      ftoa_pkg::ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          cmd.last     = 1'b1;
          state_next   = ftoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftoa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ftoa_dp.sv @@
// ----------------------------------------------------------------------------
// ftoa_dp
// Datapath: float decode, shared multiplier, divide-by-ten step, digit
// buffers, configuration register and the output register.
// ----------------------------------------------------------------------------
module ftoa_dp #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  input  logic [3:0]           frac_digits,
  // input payload
  input  logic [31:0]          value_bits,
  // result channel
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           char_code,
  output logic                 last,
  output logic                 status,
  // control
  input  ftoa_pkg::ftoa_cmd_t  cmd,
  output ftoa_pkg::ftoa_stat_t stat
);

  localparam int FIDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;

  logic [3:0]  cfg_frac;
  logic [3:0]  dcnt;
  logic        neg;
  logic        err;
  logic [31:0] ival;
  logic [23:0] fnum;
  logic [7:0]  kshift;
  logic [31:0] fval;
  logic [63:0] prod;
  logic [3:0]  icnt;
  logic [3:0]  fcnt;
  logic [3:0]  int_dig  [10];
  logic [3:0]  frac_dig [MAX_FRAC_DIGITS];

  // decode
  logic        dec_sign;
  logic [7:0]  dec_exp;
  logic [7:0]  eff_exp;
  logic [23:0] dec_sig;
  logic [7:0]  k8;
  logic [31:0] ival_ld;
  logic [23:0] fnum_ld;
  logic [7:0]  k_ld;

  // multiply and divide step
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] dvd;
  logic [31:0] q32;
  logic [31:0] rem32;
  logic [3:0]  digit;
  logic [63:0] fshifted;
  logic [3:0]  iaddr;
  logic [3:0]  faddr;
  logic [7:0]  char_sel;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_frac <= 4'd4;
    end else if (cfg_valid) begin
      cfg_frac <= frac_digits;
    end
  end

  // clamp digits after the point
  assign dcnt = (cfg_frac > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : cfg_frac;

  // split the float into integer part and fraction numerator
  always_comb begin
    dec_sign = value_bits[31];
    dec_exp  = value_bits[30:23];
    dec_sig  = {(dec_exp != 8'd0), value_bits[22:0]};
    eff_exp  = (dec_exp == 8'd0) ? 8'd1 : dec_exp;
    k8       = ftoa_pkg::EXP_UNIT - eff_exp;
    ival_ld  = '0;
    fnum_ld  = '0;
    k_ld     = '0;
    if (eff_exp >= ftoa_pkg::EXP_UNIT) begin
      ival_ld = {8'd0, dec_sig} << 3'(eff_exp - ftoa_pkg::EXP_UNIT);
    end else if (k8 < 8'd24) begin
      ival_ld = {8'd0, dec_sig >> k8[4:0]};
      fnum_ld = dec_sig & ((24'd1 << k8[4:0]) - 24'd1);
      k_ld    = k8;
    end else begin
      fnum_ld = dec_sig;
      k_ld    = k8;
    end
  end

  // shared multiplier operands
  always_comb begin
    if (cmd.fmul) begin
      mul_a = {8'd0, fnum};
      mul_b = {2'd0, ftoa_pkg::pow10(dcnt)};
    end else if (cmd.frmul) begin
      mul_a = fval;
      mul_b = ftoa_pkg::RECIP10;
    end else begin
      mul_a = ival;
      mul_b = ftoa_pkg::RECIP10;
    end
  end

  // quotient and remainder of the divide-by-ten step
  assign dvd      = cmd.frdiv ? fval : ival;
  assign q32      = {3'd0, prod[63:ftoa_pkg::RECIP_SH]};
  assign rem32    = dvd - (q32 << 3) - (q32 << 1);
  assign digit    = rem32[3:0];
  assign fshifted = prod >> kshift;
  assign iaddr    = icnt - 4'd1;
  assign faddr    = fcnt - 4'd1;

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      icnt <= '0;
      fcnt <= '0;
      err  <= 1'b0;
      neg  <= 1'b0;
    end else begin
      if (cmd.load) begin
        err    <= (dec_exp >= ftoa_pkg::EXP_ERR);
        neg    <= dec_sign && (dec_sig != 24'd0);
        ival   <= ival_ld;
        fnum   <= fnum_ld;
        kshift <= k_ld;
        icnt   <= '0;
        fcnt   <= '0;
      end
      if (cmd.fmul || cmd.imul || cmd.frmul) begin
        prod <= mul_a * mul_b;
      end
      if (cmd.fshift) begin
        fval <= fshifted[31:0];
      end
      if (cmd.idiv) begin
        int_dig[icnt] <= digit;
        ival          <= q32;
        icnt          <= icnt + 4'd1;
      end
      if (cmd.frdiv) begin
        frac_dig[fcnt[FIDX_W-1:0]] <= digit;
        fval                       <= q32;
        fcnt                       <= fcnt + 4'd1;
      end
      if (cmd.emit_int) begin
        icnt <= iaddr;
      end
      if (cmd.emit_frac) begin
        fcnt <= faddr;
      end
    end
  end

  // character select
  always_comb begin
    if (cmd.emit_sign) begin
      char_sel = ftoa_pkg::CHAR_MINUS;
    end else if (cmd.emit_int) begin
      char_sel = ftoa_pkg::CHAR_ZERO + {4'd0, int_dig[iaddr]};
    end else if (cmd.emit_point) begin
      char_sel = ftoa_pkg::CHAR_POINT;
    end else if (cmd.emit_frac) begin
      char_sel = ftoa_pkg::CHAR_ZERO + {4'd0, frac_dig[faddr[FIDX_W-1:0]]};
    end else begin
      char_sel = ftoa_pkg::CHAR_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_int || cmd.emit_point ||
                 cmd.emit_frac || cmd.emit_err) begin
      out_valid <= 1'b1;
      char_code <= char_sel;
      last      <= cmd.last;
      status    <= cmd.emit_err;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    stat          = '0;
    stat.err      = err;
    stat.neg      = neg;
    stat.d_zero   = (dcnt == 4'd0);
    stat.q_zero   = (q32 == 32'd0);
    stat.f_last   = ((fcnt + 4'd1) == dcnt);
    stat.int_one  = (icnt == 4'd1);
    stat.frac_one = (fcnt == 4'd1);
    stat.out_free = !out_valid || !out_stall;
  end

endmodule
